[rtl/core/epcrw_pkg.sv]
package epcrw_pkg;

	// Width of the row-major byte index before the range check
	localparam int IDX_W      = 17;
	// Widest plane address the panel size range can call for
	localparam int RAM_ADDR_W = 15;
	localparam int ARG_SLOTS  = 8;

	// Controller command codes
	localparam logic [7:0] CMD_SOFT_RESET = 8'h12;
	localparam logic [7:0] CMD_ENTRY_MODE = 8'h11;
	localparam logic [7:0] CMD_REFRESH    = 8'h20;
	localparam logic [7:0] CMD_WRITE_BW   = 8'h24;
	localparam logic [7:0] CMD_WRITE_RED  = 8'h26;
	localparam logic [7:0] CMD_WIN_X      = 8'h44;
	localparam logic [7:0] CMD_WIN_Y      = 8'h45;
	localparam logic [7:0] CMD_CNT_X      = 8'h4E;
	localparam logic [7:0] CMD_CNT_Y      = 8'h4F;

	// Plane contents after a reset
	localparam logic [7:0] BW_FILL  = 8'hFF;
	localparam logic [7:0] RED_FILL = 8'h00;

	typedef enum logic [1:0] {
		ACT_SPI        = 2'd0,
		ACT_RESET_PIN  = 2'd1,
		ACT_DELAY_DONE = 2'd2,
		ACT_READ       = 2'd3
	} epcrw_action_t;

	typedef enum logic [1:0] {
		DLY_NONE    = 2'd0,
		DLY_RESET   = 2'd1,
		DLY_REFRESH = 2'd2
	} epcrw_delay_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_RDATA
	} epcrw_state_t;

	typedef struct packed {
		epcrw_action_t action;
		logic          chip_selected;
		logic          data_command;
		logic [7:0]    byte_value;
		logic [12:0]   read_address;
		logic          read_plane;
	} epcrw_in_t;

	typedef struct packed {
		logic       busy_res;
		logic [1:0] delay_request;
		logic [7:0] read_data;
		logic [5:0] ram_column;
		logic [8:0] ram_row;
	} epcrw_out_t;

	// Plane write request from the command unit
	typedef struct packed {
		logic                  we_bw;
		logic                  we_red;
		logic [RAM_ADDR_W-1:0] addr;
		logic [7:0]            wdata;
	} epcrw_ram_req_t;

	// Register state after the current item
	typedef struct packed {
		logic         busy;
		epcrw_delay_t delay;
		logic [5:0]   ram_column;
		logic [8:0]   ram_row;
		logic         clear_req;
	} epcrw_status_t;

endpackage

[rtl/core/epaper_controller_spi_ram_writer_unit.sv]
// A result is registered in the output register from the execute state, or, for a plane read,
// from the read-data state that follows it. The unit takes no new item until the last one is
// through; the output register holding an untaken result stalls the next item in its execute state.
// Reset (arst_n, the reset-pin action or the software reset command) sweeps both planes,
// one byte a cycle, PANEL_WIDTH*PANEL_HEIGHT/8 bytes (5000 by default), taking no item.
module epaper_controller_spi_ram_writer_unit import epcrw_pkg::*; #(
	parameter int PANEL_WIDTH  = 200,
	parameter int PANEL_HEIGHT = 200
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  epcrw_in_t  in_item,
	output logic       out_valid,
	input  logic       out_ready,
	output epcrw_out_t out_item
);

	localparam int PLANE_BYTES = (PANEL_WIDTH * PANEL_HEIGHT) / 8;
	localparam int ADDR_W      = (PLANE_BYTES > 1) ? $clog2(PLANE_BYTES) : 1;

	epcrw_state_t   state_q, state_d;
	epcrw_in_t      item_q;
	epcrw_out_t     out_q;
	logic           out_valid_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic           clearing, clr_done, slot_free;
	logic           commit, rd_en, load_exec, load_read;
	epcrw_ram_req_t ram_req;
	epcrw_status_t  status;
	logic [IDX_W-1:0]  rd_idx;
	logic           rd_ok;
	logic           bw_we, red_we;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [7:0]     bw_wdata, red_wdata, bw_rd, red_rd, rd_byte;

	epcrw_cmd_regs #(
		.PANEL_WIDTH  (PANEL_WIDTH),
		.PANEL_HEIGHT (PANEL_HEIGHT)
	) u_cmd (
		.clk     (clk),
		.arst_n  (arst_n),
		.commit  (commit),
		.item    (item_q),
		.ram_req (ram_req),
		.status  (status)
	);

	// Plane ports: clearing sweep or stream write, read from the held item
	assign clearing  = state_q == ST_CLEAR;
	assign clr_done  = clr_addr_q == ADDR_W'(PLANE_BYTES - 1);
	assign bw_we     = clearing || ram_req.we_bw;
	assign red_we    = clearing || ram_req.we_red;
	assign waddr     = clearing ? clr_addr_q : ram_req.addr[ADDR_W-1:0];
	assign bw_wdata  = clearing ? BW_FILL : ram_req.wdata;
	assign red_wdata = clearing ? RED_FILL : ram_req.wdata;
	assign rd_idx    = IDX_W'(item_q.read_address);
	assign rd_ok     = rd_idx < IDX_W'(PLANE_BYTES);
	assign raddr     = rd_idx[ADDR_W-1:0];

	epcrw_plane_ram #(
		.DEPTH  (PLANE_BYTES),
		.ADDR_W (ADDR_W)
	) u_bw_ram (
		.clk     (clk),
		.we      (bw_we),
		.waddr   (waddr),
		.wdata   (bw_wdata),
		.re      (rd_en),
		.raddr   (raddr),
		.rd_data (bw_rd)
	);

	epcrw_plane_ram #(
		.DEPTH  (PLANE_BYTES),
		.ADDR_W (ADDR_W)
	) u_red_ram (
		.clk     (clk),
		.we      (red_we),
		.waddr   (waddr),
		.wdata   (red_wdata),
		.re      (rd_en),
		.raddr   (raddr),
		.rd_data (red_rd)
	);

	assign slot_free = !out_valid_q || out_ready;
	assign rd_byte   = rd_ok ? (item_q.read_plane ? red_rd : bw_rd) : 8'h00;

	// Sequence: clear sweep, take item, execute, collect read data
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		commit    = 1'b0;
		rd_en     = 1'b0;
		load_exec = 1'b0;
		load_read = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				if (clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (slot_free) begin
					commit = 1'b1;
					if (item_q.action == ACT_READ) begin
						rd_en   = 1'b1;
						state_d = ST_RDATA;
					end else begin
						load_exec = 1'b1;
						state_d   = status.clear_req ? ST_CLEAR : ST_IDLE;
					end
				end
			end
			ST_RDATA: begin
				load_read = 1'b1;
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Advance the sweep address, hold it at zero outside the sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (clearing && !clr_done) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end else begin
			clr_addr_q <= '0;
		end
	end

	// Hold the accepted item
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= in_item;
		end
	end

	// Output register: load a result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_exec || load_read) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_exec) begin
			out_q.busy_res      <= status.busy;
			out_q.delay_request <= status.delay;
			out_q.read_data     <= 8'h00;
			out_q.ram_column    <= status.ram_column;
			out_q.ram_row       <= status.ram_row;
		end else if (load_read) begin
			out_q.busy_res      <= status.busy;
			out_q.delay_request <= DLY_NONE;
			out_q.read_data     <= rd_byte;
			out_q.ram_column    <= status.ram_column;
			out_q.ram_row       <= status.ram_row;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

[rtl/core/epcrw_plane_ram.sv]
module epcrw_plane_ram #(
	parameter int DEPTH  = 5000,
	parameter int ADDR_W = 13
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [7:0]        wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [7:0]        rd_data
);

	logic [7:0] mem [DEPTH];

	// Write one byte, read one byte with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_data <= mem[raddr];
		end
	end

endmodule

[rtl/core/epcrw_cmd_regs.sv]
module epcrw_cmd_regs import epcrw_pkg::*; #(
	parameter int PANEL_WIDTH  = 200,
	parameter int PANEL_HEIGHT = 200
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           commit,
	input  epcrw_in_t      item,
	output epcrw_ram_req_t ram_req,
	output epcrw_status_t  status
);

	localparam int ROW_BYTES   = PANEL_WIDTH / 8;
	localparam int PLANE_BYTES = (PANEL_WIDTH * PANEL_HEIGHT) / 8;
	localparam logic [5:0] WIN_X_LAST_RST = 6'(ROW_BYTES - 1);
	localparam logic [8:0] WIN_Y_LAST_RST = 9'(PANEL_HEIGHT - 1);

	logic [2:0] entry_mode_q, entry_mode_n;
	logic [5:0] win_x_first_q, win_x_first_n, win_x_last_q, win_x_last_n;
	logic [8:0] win_y_first_q, win_y_first_n, win_y_last_q, win_y_last_n;
	logic [5:0] cnt_x_q, cnt_x_n;
	logic [8:0] cnt_y_q, cnt_y_n;
	logic [7:0] cmd_q, cmd_n;
	logic       strm_bw_q, strm_bw_n, strm_red_q, strm_red_n;
	logic [7:0] args_q [ARG_SLOTS];
	logic [7:0] args_n [ARG_SLOTS];
	logic [3:0] arg_cnt_q, arg_cnt_n;
	logic       busy_q, busy_n;

	logic             soft_reset, refresh, run_cmd, ram_wr;
	epcrw_delay_t     delay;
	logic [IDX_W-1:0] wr_idx;
	logic             wr_ok;

	// Address counter step as the entry mode says
	logic       x_up, y_up, y_major, wrap_x, wrap_y;
	logic [5:0] step_x, adv_x;
	logic [8:0] step_y, adv_y;

	assign x_up    = entry_mode_q[0];
	assign y_up    = entry_mode_q[1];
	assign y_major = entry_mode_q[2];

	always_comb begin
		if (x_up) begin
			wrap_x = cnt_x_q >= win_x_last_q;
			step_x = wrap_x ? win_x_first_q : cnt_x_q + 6'd1;
		end else begin
			wrap_x = cnt_x_q <= win_x_first_q;
			step_x = wrap_x ? win_x_last_q : cnt_x_q - 6'd1;
		end
		if (y_up) begin
			wrap_y = cnt_y_q >= win_y_last_q;
			step_y = wrap_y ? win_y_first_q : cnt_y_q + 9'd1;
		end else begin
			wrap_y = cnt_y_q <= win_y_first_q;
			step_y = wrap_y ? win_y_last_q : cnt_y_q - 9'd1;
		end
		if (y_major) begin
			adv_y = step_y;
			adv_x = wrap_y ? step_x : cnt_x_q;
		end else begin
			adv_x = step_x;
			adv_y = wrap_x ? step_y : cnt_y_q;
		end
	end

	// Row-major byte index of the counters
	assign wr_idx = IDX_W'(cnt_y_q) * IDX_W'(ROW_BYTES) + IDX_W'(cnt_x_q);
	assign wr_ok  = wr_idx < IDX_W'(PLANE_BYTES);

	// Decode the item and work out the next register state
	always_comb begin
		entry_mode_n  = entry_mode_q;
		win_x_first_n = win_x_first_q;
		win_x_last_n  = win_x_last_q;
		win_y_first_n = win_y_first_q;
		win_y_last_n  = win_y_last_q;
		cnt_x_n       = cnt_x_q;
		cnt_y_n       = cnt_y_q;
		cmd_n         = cmd_q;
		strm_bw_n     = strm_bw_q;
		strm_red_n    = strm_red_q;
		args_n        = args_q;
		arg_cnt_n     = arg_cnt_q;
		busy_n        = busy_q;
		soft_reset    = 1'b0;
		refresh       = 1'b0;
		run_cmd       = 1'b0;
		ram_wr        = 1'b0;
		delay         = DLY_NONE;

		if (commit) begin
			case (item.action)
				ACT_SPI: begin
					if (item.chip_selected) begin
						if (!item.data_command) begin
							strm_bw_n  = 1'b0;
							strm_red_n = 1'b0;
							cmd_n      = item.byte_value;
							arg_cnt_n  = '0;
							if (item.byte_value == CMD_SOFT_RESET) begin
								soft_reset = 1'b1;
							end else if (item.byte_value == CMD_REFRESH) begin
								refresh = 1'b1;
							end else if (item.byte_value == CMD_WRITE_BW) begin
								strm_bw_n = 1'b1;
							end else if (item.byte_value == CMD_WRITE_RED) begin
								strm_red_n = 1'b1;
							end
						end else if (strm_bw_q || strm_red_q) begin
							ram_wr  = wr_ok;
							cnt_x_n = adv_x;
							cnt_y_n = adv_y;
						end else if (arg_cnt_q < 4'(ARG_SLOTS)) begin
							args_n[arg_cnt_q[2:0]] = item.byte_value;
							arg_cnt_n = arg_cnt_q + 4'd1;
							run_cmd   = 1'b1;
						end
					end
				end
				ACT_RESET_PIN: begin
					soft_reset = 1'b1;
				end
				ACT_DELAY_DONE: begin
					busy_n = 1'b0;
				end
				default: begin
				end
			endcase
		end

		// Rerun the current command with the new argument
		if (run_cmd) begin
			case (cmd_q)
				CMD_SOFT_RESET: begin
					soft_reset = 1'b1;
				end
				CMD_ENTRY_MODE: begin
					if (arg_cnt_n == 4'd1) begin
						entry_mode_n = args_n[0][2:0];
					end
				end
				CMD_WIN_X: begin
					if (arg_cnt_n == 4'd2) begin
						win_x_first_n = args_n[0][5:0];
						win_x_last_n  = args_n[1][5:0];
						cnt_x_n       = args_n[0][5:0];
					end
				end
				CMD_WIN_Y: begin
					if (arg_cnt_n == 4'd4) begin
						win_y_first_n = {args_n[1][0], args_n[0]};
						win_y_last_n  = {args_n[3][0], args_n[2]};
						cnt_y_n       = {args_n[1][0], args_n[0]};
					end
				end
				CMD_CNT_X: begin
					if (arg_cnt_n == 4'd1) begin
						cnt_x_n = args_n[0][5:0];
					end
				end
				CMD_CNT_Y: begin
					if (arg_cnt_n == 4'd2) begin
						cnt_y_n = {args_n[1][0], args_n[0]};
					end
				end
				CMD_REFRESH: begin
					refresh = 1'b1;
				end
				default: begin
				end
			endcase
		end

		if (refresh) begin
			busy_n = 1'b1;
			delay  = DLY_REFRESH;
		end

		// Restore everything but busy and the argument slots
		if (soft_reset) begin
			entry_mode_n  = 3'd3;
			win_x_first_n = '0;
			win_x_last_n  = WIN_X_LAST_RST;
			win_y_first_n = '0;
			win_y_last_n  = WIN_Y_LAST_RST;
			cnt_x_n       = '0;
			cnt_y_n       = '0;
			cmd_n         = '0;
			strm_bw_n     = 1'b0;
			strm_red_n    = 1'b0;
			arg_cnt_n     = '0;
			busy_n        = 1'b1;
			delay         = DLY_RESET;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_mode_q  <= 3'd3;
			win_x_first_q <= '0;
			win_x_last_q  <= WIN_X_LAST_RST;
			win_y_first_q <= '0;
			win_y_last_q  <= WIN_Y_LAST_RST;
			cnt_x_q       <= '0;
			cnt_y_q       <= '0;
			cmd_q         <= '0;
			strm_bw_q     <= 1'b0;
			strm_red_q    <= 1'b0;
			arg_cnt_q     <= '0;
			busy_q        <= 1'b0;
			for (int i = 0; i < ARG_SLOTS; i++) begin
				args_q[i] <= '0;
			end
		end else begin
			entry_mode_q  <= entry_mode_n;
			win_x_first_q <= win_x_first_n;
			win_x_last_q  <= win_x_last_n;
			win_y_first_q <= win_y_first_n;
			win_y_last_q  <= win_y_last_n;
			cnt_x_q       <= cnt_x_n;
			cnt_y_q       <= cnt_y_n;
			cmd_q         <= cmd_n;
			strm_bw_q     <= strm_bw_n;
			strm_red_q    <= strm_red_n;
			arg_cnt_q     <= arg_cnt_n;
			busy_q        <= busy_n;
			args_q        <= args_n;
		end
	end

	assign ram_req.we_bw  = ram_wr && strm_bw_q;
	assign ram_req.we_red = ram_wr && strm_red_q;
	assign ram_req.addr   = wr_idx[RAM_ADDR_W-1:0];
	assign ram_req.wdata  = item.byte_value;

	assign status.busy       = busy_n;
	assign status.delay      = delay;
	assign status.ram_column = cnt_x_n;
	assign status.ram_row    = cnt_y_n;
	assign status.clear_req  = soft_reset;

endmodule
